// ----- sv/qbz_pkg.sv -----
// Shared types and constants for the quadratic Bezier segment generator.
`timescale 1ns / 1ps

package qbz_pkg;

    localparam int COORD_W   = 16;
    localparam int THICK_W   = 16;
    localparam int COLOR_W   = 32;
    // Forward-difference accumulators; sized for the largest segment count.
    localparam int ACC_W     = 32;
    localparam int S_TDATA_W = 6 * COORD_W + THICK_W + COLOR_W;
    localparam int M_TDATA_W = 4 * COORD_W + THICK_W + COLOR_W;

    // Raw curve request as taken from the input stream.
    typedef struct packed {
        logic [COLOR_W-1:0]        color;
        logic [THICK_W-1:0]        thickness;
        logic signed [COORD_W-1:0] control_y;
        logic signed [COORD_W-1:0] control_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_x;
    } curve_in_t;

    // One axis of a prepared curve: biased, doubled numerator and its differences.
    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] d1;
        logic signed [ACC_W-1:0] d2;
    } axis_t;

    // Prepared curve queued between front and back.
    typedef struct packed {
        axis_t              ax;
        axis_t              ay;
        logic [THICK_W-1:0] thickness;
        logic [COLOR_W-1:0] color;
    } curve_t;

    // Sign-extend a coordinate to accumulator width.
    function automatic logic signed [ACC_W-1:0] ext_coord(input logic [COORD_W-1:0] v);
        ext_coord = {{(ACC_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

endpackage

// ----- sv/qbz_front.sv -----
// Front end: registers a curve request and prepares its forward-difference terms.
`timescale 1ns / 1ps

module qbz_front #(
    parameter int SEGMENTS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qbz_pkg::curve_in_t in_data,
    output logic               push_valid,
    input  logic               push_ready,
    output qbz_pkg::curve_t    push_data
);
    import qbz_pkg::*;

    localparam int NN  = SEGMENTS * SEGMENTS;
    localparam int DEN = 2 * NN;
    localparam logic [ACC_W-1:0]        K_ACC_MUL = ACC_W'(DEN);
    localparam logic [ACC_W-1:0]        K_ACC_ADD = ACC_W'(NN);
    localparam logic signed [ACC_W-1:0] K_D1_S    = ACC_W'(2 * (1 - 2 * SEGMENTS));
    localparam logic signed [ACC_W-1:0] K_D1_C    = ACC_W'(4 * (SEGMENTS - 1));
    localparam logic signed [ACC_W-1:0] K_D1_E    = ACC_W'(2);
    localparam logic signed [ACC_W-1:0] K_D2_SE   = ACC_W'(4);
    localparam logic signed [ACC_W-1:0] K_D2_C    = ACC_W'(-8);

    logic      req_valid_reg;
    logic      req_valid_next;
    curve_in_t req_reg;

    // Take a new request when the holding register is empty or drains this cycle.
    assign in_ready = !req_valid_reg || push_ready;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_valid && in_ready)
        begin
            req_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
    end

    // Prepare one axis: acc = 2*N^2*(S + 32768) + N^2, then doubled first
    // and second differences of the numerator.
    function automatic axis_t prep_axis(input logic [COORD_W-1:0] s,
                                        input logic [COORD_W-1:0] c,
                                        input logic [COORD_W-1:0] e);
        axis_t                   a;
        logic [ACC_W-1:0]        s_off;
        logic signed [ACC_W-1:0] sv;
        logic signed [ACC_W-1:0] cv;
        logic signed [ACC_W-1:0] ev;
        s_off = {{(ACC_W-COORD_W){1'b0}}, s ^ {1'b1, {(COORD_W-1){1'b0}}}};
        sv    = ext_coord(s);
        cv    = ext_coord(c);
        ev    = ext_coord(e);
        a.acc = signed'(s_off * K_ACC_MUL + K_ACC_ADD);
        a.d1  = sv * K_D1_S + cv * K_D1_C + ev * K_D1_E;
        a.d2  = (sv + ev) * K_D2_SE + cv * K_D2_C;
        prep_axis = a;
    endfunction

    always_comb
    begin
        push_data.ax        = prep_axis(req_reg.start_x, req_reg.control_x, req_reg.end_x);
        push_data.ay        = prep_axis(req_reg.start_y, req_reg.control_y, req_reg.end_y);
        push_data.thickness = req_reg.thickness;
        push_data.color     = req_reg.color;
    end

    assign push_valid = req_valid_reg;

endmodule

// ----- sv/qbz_queue.sv -----
// Short queue of prepared curves between front and back.
`timescale 1ns / 1ps

module qbz_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  qbz_pkg::curve_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output qbz_pkg::curve_t pop_data
);
    import qbz_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PW     = $clog2(QDEPTH);
    localparam int CNTW   = $clog2(QDEPTH + 1);

    curve_t          slot_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CNTW'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(QDEPTH))
        else $error("queue fill level beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill level did not rise on push");

endmodule

// ----- sv/qbz_back.sv -----
// Back end: walks each curve's points and emits one segment per cycle unless stalled.
`timescale 1ns / 1ps

module qbz_back #(
    parameter int SEGMENTS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  qbz_pkg::curve_t             pop_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [qbz_pkg::COORD_W-1:0] from_x,
    output logic [qbz_pkg::COORD_W-1:0] from_y,
    output logic [qbz_pkg::COORD_W-1:0] to_x,
    output logic [qbz_pkg::COORD_W-1:0] to_y,
    output logic [qbz_pkg::THICK_W-1:0] line_thickness,
    output logic [qbz_pkg::COLOR_W-1:0] line_color,
    output logic                        last
);
    import qbz_pkg::*;

    localparam int NN    = SEGMENTS * SEGMENTS;
    localparam int DEN   = 2 * NN;
    localparam int LOGD  = $clog2(DEN);
    // Dividend stays below 65536 * DEN.
    localparam int DW    = COORD_W + LOGD;
    localparam int MW    = DW + 1;
    localparam int SH    = DW + LOGD;
    localparam int PRODW = DW + MW;
    localparam int CW    = $clog2(SEGMENTS + 1);
    localparam logic [63:0]   RECIP_L = ((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN);
    localparam logic [MW-1:0] RECIP   = RECIP_L[MW-1:0];
    localparam logic [COORD_W-1:0] SIGN_FLIP = {1'b1, {(COORD_W-1){1'b0}}};

    logic adv;

    // Stage A: point iterator.
    logic               a_valid_reg;
    logic               a_valid_next;
    axis_t              a_x_reg;
    axis_t              a_x_next;
    axis_t              a_y_reg;
    axis_t              a_y_next;
    logic [CW-1:0]      a_cnt_reg;
    logic [CW-1:0]      a_cnt_next;
    logic [THICK_W-1:0] a_thick_reg;
    logic [THICK_W-1:0] a_thick_next;
    logic [COLOR_W-1:0] a_color_reg;
    logic [COLOR_W-1:0] a_color_next;
    logic               a_take;
    logic               a_last;

    // Stage B: reciprocal products.
    logic               b_valid_reg;
    logic [PRODW-1:0]   b_prod_x_reg;
    logic [PRODW-1:0]   b_prod_y_reg;
    logic [THICK_W-1:0] b_thick_reg;
    logic [COLOR_W-1:0] b_color_reg;
    logic               b_first_reg;
    logic               b_last_reg;
    logic [COORD_W-1:0] b_qx;
    logic [COORD_W-1:0] b_qy;

    // Stage C: output register.
    logic               out_valid_reg;
    logic [COORD_W-1:0] from_x_reg;
    logic [COORD_W-1:0] from_y_reg;
    logic [COORD_W-1:0] to_x_reg;
    logic [COORD_W-1:0] to_y_reg;
    logic [THICK_W-1:0] thick_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               last_reg;

    // Move the whole pipeline when the output slot is free or being taken; an empty iterator may also load.
    assign adv       = !out_valid_reg || out_ready;
    assign a_take    = adv || !a_valid_reg;
    assign a_last    = (a_cnt_reg == CW'(SEGMENTS));
    assign pop_ready = a_take && (!a_valid_reg || a_last);

    // Step the forward differences, or load the next curve.
    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_x_next     = a_x_reg;
        a_y_next     = a_y_reg;
        a_cnt_next   = a_cnt_reg;
        a_thick_next = a_thick_reg;
        a_color_next = a_color_reg;
        if (a_take)
        begin
            if (a_valid_reg && !a_last)
            begin
                a_x_next.acc = a_x_reg.acc + a_x_reg.d1;
                a_x_next.d1  = a_x_reg.d1 + a_x_reg.d2;
                a_y_next.acc = a_y_reg.acc + a_y_reg.d1;
                a_y_next.d1  = a_y_reg.d1 + a_y_reg.d2;
                a_cnt_next   = a_cnt_reg + 1'b1;
            end
            else if (pop_valid)
            begin
                a_valid_next = 1'b1;
                a_x_next     = pop_data.ax;
                a_y_next     = pop_data.ay;
                a_cnt_next   = '0;
                a_thick_next = pop_data.thickness;
                a_color_next = pop_data.color;
            end
            else
            begin
                a_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            a_cnt_reg     <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            a_cnt_reg   <= a_cnt_next;
            if (adv)
            begin
                b_valid_reg   <= a_valid_reg;
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_x_reg     <= a_x_next;
        a_y_reg     <= a_y_next;
        a_thick_reg <= a_thick_next;
        a_color_reg <= a_color_next;
    end

    // Divide by 2*N^2 through a reciprocal multiply, one per axis.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_prod_x_reg <= PRODW'(a_x_reg.acc[DW-1:0]) * PRODW'(RECIP);
            b_prod_y_reg <= PRODW'(a_y_reg.acc[DW-1:0]) * PRODW'(RECIP);
            b_thick_reg  <= a_thick_reg;
            b_color_reg  <= a_color_reg;
            b_first_reg  <= (a_cnt_reg == '0);
            b_last_reg   <= a_last;
        end
    end

    // Remove the 32768 bias by flipping the sign bit.
    assign b_qx = b_prod_x_reg[SH +: COORD_W] ^ SIGN_FLIP;
    assign b_qy = b_prod_y_reg[SH +: COORD_W] ^ SIGN_FLIP;

    // Build the segment; its start is the previous end unless the curve just began.
    always_ff @(posedge clk)
    begin
        if (adv && b_valid_reg)
        begin
            from_x_reg <= b_first_reg ? b_qx : to_x_reg;
            from_y_reg <= b_first_reg ? b_qy : to_y_reg;
            to_x_reg   <= b_qx;
            to_y_reg   <= b_qy;
            thick_reg  <= b_thick_reg;
            color_reg  <= b_color_reg;
            last_reg   <= b_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign from_x         = from_x_reg;
    assign from_y         = from_y_reg;
    assign to_x           = to_x_reg;
    assign to_y           = to_y_reg;
    assign line_thickness = thick_reg;
    assign line_color     = color_reg;
    assign last           = last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> a_cnt_reg <= CW'(SEGMENTS))
        else $error("segment counter past end of curve");

    a_iter_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !adv |=> a_valid_reg && $stable(a_cnt_reg))
        else $error("iterator moved while pipeline stalled");

    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        adv && b_valid_reg && !b_first_reg |=>
            from_x_reg == $past(to_x_reg) && from_y_reg == $past(to_y_reg))
        else $error("segment does not start at previous end point");

endmodule

// ----- sv/quad_bezier_segment_generator.sv -----
// Top level of the quadratic Bezier segment generator.
//
// Each request on the slave stream is one quadratic Bezier curve; the block
// returns SEGMENTS+1 line segments for it on the master stream, one segment
// per cycle while the consumer keeps tready high; the next curve follows with
// no gap if it is already queued. The rate is set by the point iterator in
// the back end, which produces one curve point per cycle by forward
// differencing unless the output stalls. A request passes a holding
// register and a two-entry queue, then three back-end stages (iterator,
// reciprocal multiply, output register) before its first segment appears.
// The first segment of a curve runs from the start point to itself; the last
// carries tlast. Points are rounded to nearest, ties toward plus infinity.
`timescale 1ns / 1ps

module quad_bezier_segment_generator #(
    parameter int SEGMENTS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x, start_y, end_x, end_y, control_x, control_y, thickness, color
    input  logic [qbz_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // from_x, from_y, to_x, to_y, line_thickness, line_color
    output logic [qbz_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import qbz_pkg::*;

    curve_in_t          in_req;
    curve_t             push_data;
    curve_t             pop_data;
    logic               push_valid;
    logic               push_ready;
    logic               pop_valid;
    logic               pop_ready;
    logic [COORD_W-1:0] from_x;
    logic [COORD_W-1:0] from_y;
    logic [COORD_W-1:0] to_x;
    logic [COORD_W-1:0] to_y;
    logic [THICK_W-1:0] line_thickness;
    logic [COLOR_W-1:0] line_color;

    // Unpack the request, first field in the lowest bits.
    assign in_req.start_x   = s_tdata[0*COORD_W +: COORD_W];
    assign in_req.start_y   = s_tdata[1*COORD_W +: COORD_W];
    assign in_req.end_x     = s_tdata[2*COORD_W +: COORD_W];
    assign in_req.end_y     = s_tdata[3*COORD_W +: COORD_W];
    assign in_req.control_x = s_tdata[4*COORD_W +: COORD_W];
    assign in_req.control_y = s_tdata[5*COORD_W +: COORD_W];
    assign in_req.thickness = s_tdata[6*COORD_W +: THICK_W];
    assign in_req.color     = s_tdata[6*COORD_W + THICK_W +: COLOR_W];

    qbz_front #(
        .SEGMENTS (SEGMENTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (in_req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    qbz_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    qbz_back #(
        .SEGMENTS (SEGMENTS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_data       (pop_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .from_x         (from_x),
        .from_y         (from_y),
        .to_x           (to_x),
        .to_y           (to_y),
        .line_thickness (line_thickness),
        .line_color     (line_color),
        .last           (m_tlast)
    );

    // Pack the segment, first field in the lowest bits.
    assign m_tdata = {line_color, line_thickness, to_y, to_x, from_y, from_x};

endmodule
